FILE: rtl/rc4_pkg.sv
// shared types and constants of the rc4 stream cipher
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

	// operation codes of an input word
	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_SCHEDULE = 2'd1;
	localparam logic [1:0] OP_CRYPT    = 2'd2;

	// register file
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_KEY_LENGTH = '0;
	localparam logic [8:0] KEY_LENGTH_RESET = 9'd1;

	localparam int unsigned PERM_DEPTH = 256;

	// commands from controller to datapath
	typedef struct packed {
		logic load_key;
		logic sched_start;
		logic init_wr;
		logic sched_rd;
		logic sched_j;
		logic sched_wr_n;
		logic sched_wr_j;
		logic crypt_start;
		logic crypt_rd_j;
		logic crypt_wr_i;
		logic crypt_wr_j;
		logic emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic n_last;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/rc4_dp.sv
// rc4 datapath: permutation and key memories, indices, result register
`timescale 1ns / 1ps
`default_nettype none

module rc4_dp #(
	parameter int unsigned KEY_DEPTH = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  rc4_pkg::cmd_t      cmd,
	output rc4_pkg::status_t   sts,
	input  wire  [8:0]         key_length,
	input  wire  [7:0]         key_index,
	input  wire  [7:0]         key_byte,
	input  wire  [7:0]         data_byte,
	input  wire                last_in,
	output logic               result_valid,
	input  wire                result_ready,
	output logic [7:0]         out_byte,
	output logic               last_out
);

	localparam int unsigned KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	logic [7:0] perm_mem [rc4_pkg::PERM_DEPTH];
	logic [7:0] key_mem  [KEY_DEPTH];

	logic [7:0] rdata_q;
	logic [7:0] krdata_q;

	logic [7:0] n_q, sj_q, i_q, j_q, a_q, b_q, t_q;
	logic [8:0] k_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       result_valid_q;
	logic [7:0] out_byte_q;
	logic       last_out_q;

	logic       perm_we;
	logic [7:0] perm_waddr, perm_wdata, perm_raddr;
	logic [7:0] sj_next;
	logic [8:0] len_eff, k_inc, k_next;
	logic [7:0] keystream;
	logic       key_we;

	assign sj_next = sj_q + rdata_q + krdata_q;

	// key length clamped to 1..KEY_DEPTH
	always_comb begin
		if (key_length == 9'd0) begin
			len_eff = 9'd1;
		end else if (key_length > 9'(KEY_DEPTH)) begin
			len_eff = 9'(KEY_DEPTH);
		end else begin
			len_eff = key_length;
		end
	end

	assign k_inc  = k_q + 9'd1;
	assign k_next = (k_inc >= len_eff) ? 9'd0 : k_inc;

	assign key_we = cmd.load_key && ({1'b0, key_index} < 9'(KEY_DEPTH));

	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = n_q;
		perm_wdata = n_q;
		if (cmd.init_wr) begin
			perm_we = 1'b1;
		end else if (cmd.sched_wr_n) begin
			perm_we    = 1'b1;
			perm_wdata = rdata_q;
		end else if (cmd.sched_wr_j) begin
			perm_we    = 1'b1;
			perm_waddr = sj_q;
			perm_wdata = a_q;
		end else if (cmd.crypt_wr_i) begin
			perm_we    = 1'b1;
			perm_waddr = i_q;
			perm_wdata = rdata_q;
		end else if (cmd.crypt_wr_j) begin
			perm_we    = 1'b1;
			perm_waddr = j_q;
			perm_wdata = a_q;
		end
	end

	always_comb begin
		perm_raddr = n_q;
		if (cmd.crypt_start) begin
			perm_raddr = i_q + 8'd1;
		end else if (cmd.crypt_rd_j) begin
			perm_raddr = j_q + rdata_q;
		end else if (cmd.crypt_wr_i) begin
			perm_raddr = a_q + rdata_q;
		end else if (cmd.crypt_wr_j) begin
			// keep entry a+b on the read port while the result register is full
			perm_raddr = t_q;
		end else if (cmd.sched_j) begin
			perm_raddr = sj_next;
		end
	end

	// memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		rdata_q <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_index[KW-1:0]] <= key_byte;
		end
		krdata_q <= key_mem[k_q[KW-1:0]];
	end

	// entry a+b may have been read before the two swap writes landed
	always_comb begin
		if (t_q == j_q) begin
			keystream = a_q;
		end else if (t_q == i_q) begin
			keystream = b_q;
		end else begin
			keystream = rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= '0;
			sj_q <= '0;
			k_q  <= '0;
			i_q  <= '0;
			j_q  <= '0;
		end else begin
			if (cmd.sched_start) begin
				n_q  <= '0;
				sj_q <= '0;
				k_q  <= '0;
				i_q  <= '0;
				j_q  <= '0;
			end
			if (cmd.init_wr) begin
				n_q <= n_q + 8'd1;
			end
			if (cmd.sched_j) begin
				sj_q <= sj_next;
			end
			if (cmd.sched_wr_j) begin
				n_q <= n_q + 8'd1;
				k_q <= k_next;
			end
			if (cmd.crypt_start) begin
				i_q <= i_q + 8'd1;
			end
			if (cmd.crypt_rd_j) begin
				j_q <= j_q + rdata_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sched_j || cmd.crypt_rd_j) begin
			a_q <= rdata_q;
		end
		if (cmd.crypt_wr_i) begin
			b_q <= rdata_q;
			t_q <= a_q + rdata_q;
		end
		if (cmd.crypt_start) begin
			data_q <= data_byte;
			last_q <= last_in;
		end
		if (cmd.emit) begin
			out_byte_q <= data_q ^ keystream;
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign sts.n_last   = (n_q == 8'hFF);
	assign sts.out_busy = result_valid_q && !result_ready;

	assign result_valid = result_valid_q;
	assign out_byte     = out_byte_q;
	assign last_out     = last_out_q;

endmodule

`default_nettype wire

FILE: rtl/rc4_ctrl.sv
// rc4 controller state machine
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_ready,
	input  wire  [1:0]        operation,
	input  rc4_pkg::status_t  sts,
	output rc4_pkg::cmd_t     cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_INIT     = 4'd1;
	localparam logic [3:0] ST_KS_RD    = 4'd2;
	localparam logic [3:0] ST_KS_J     = 4'd3;
	localparam logic [3:0] ST_KS_WR_N  = 4'd4;
	localparam logic [3:0] ST_KS_WR_J  = 4'd5;
	localparam logic [3:0] ST_CR_RD_J  = 4'd6;
	localparam logic [3:0] ST_CR_WR_I  = 4'd7;
	localparam logic [3:0] ST_CR_WR_J  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						rc4_pkg::OP_LOAD: begin
							cmd.load_key = 1'b1;
						end
						rc4_pkg::OP_SCHEDULE: begin
							cmd.sched_start = 1'b1;
							state_d = ST_INIT;
						end
						rc4_pkg::OP_CRYPT: begin
							cmd.crypt_start = 1'b1;
							state_d = ST_CR_RD_J;
						end
						default: begin
						end
					endcase
				end
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.n_last) begin
					state_d = ST_KS_RD;
				end
			end
			ST_KS_RD: begin
				cmd.sched_rd = 1'b1;
				state_d = ST_KS_J;
			end
			ST_KS_J: begin
				cmd.sched_j = 1'b1;
				state_d = ST_KS_WR_N;
			end
			ST_KS_WR_N: begin
				cmd.sched_wr_n = 1'b1;
				state_d = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				cmd.sched_wr_j = 1'b1;
				state_d = sts.n_last ? ST_IDLE : ST_KS_RD;
			end
			ST_CR_RD_J: begin
				cmd.crypt_rd_j = 1'b1;
				state_d = ST_CR_WR_I;
			end
			ST_CR_WR_I: begin
				cmd.crypt_wr_i = 1'b1;
				state_d = ST_CR_WR_J;
			end
			ST_CR_WR_J: begin
				// rewriting the same entry while the result register is full is harmless
				cmd.crypt_wr_j = 1'b1;
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_crypt_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == rc4_pkg::OP_CRYPT |=> state_q == ST_CR_RD_J)
		else $error("crypt word did not start keystream step");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("result emitted into a full result register");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CR_WR_J && !sts.out_busy |=> state_q == ST_IDLE)
		else $error("keystream step did not finish");

	a_init_to_sched: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT && sts.n_last |=> state_q == ST_KS_RD)
		else $error("identity fill did not hand over to key schedule");

endmodule

`default_nettype wire

FILE: rtl/rc4_stream_cipher.sv
// rc4 stream cipher top level: register port, controller and datapath
`timescale 1ns / 1ps
`default_nettype none

// crypt word: CR_RD_J, CR_WR_I, CR_WR_J (held while the result register is full);
//   no word is taken before idle; the single permutation write port takes both swap writes
// load word: key byte written on acceptance; schedule word: 256-entry fill, 256 swap steps
// a finished result waits in its own register while the next word is accepted
// reset (async, active low) clears the indices and sets key_length to 1;
//   the permutation and key memories are left as they are until written

module rc4_stream_cipher #(
	parameter int unsigned KEY_DEPTH = 256
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [rc4_pkg::ADDR_W-1:0]   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// input words
	input  wire                          item_valid,
	output logic                         item_ready,
	input  wire  [1:0]                   operation,
	input  wire  [7:0]                   key_index,
	input  wire  [7:0]                   key_byte,
	input  wire  [7:0]                   data_byte,
	input  wire                          last_in,
	// result words
	output logic                         result_valid,
	input  wire                          result_ready,
	output logic [7:0]                   out_byte,
	output logic                         last_out
);

	rc4_pkg::cmd_t    cmd;
	rc4_pkg::status_t sts;

	logic [8:0] key_length_q;
	logic       reg_hit;

	// one register: key_length at byte address 0
	assign reg_hit = (paddr[rc4_pkg::ADDR_W-1:2] == rc4_pkg::REG_KEY_LENGTH);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= rc4_pkg::KEY_LENGTH_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			key_length_q <= pwdata[8:0];
		end
	end

	// reads outside the register map return zero
	assign prdata = reg_hit ? {23'd0, key_length_q} : 32'd0;

	// sequencer: fill, key schedule swaps and keystream steps
	rc4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.operation  (operation),
		.sts        (sts),
		.cmd        (cmd)
	);

	// memories, indices and the result register
	rc4_dp #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.key_length   (key_length_q),
		.key_index    (key_index),
		.key_byte     (key_byte),
		.data_byte    (data_byte),
		.last_in      (last_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.last_out     (last_out)
	);

endmodule

`default_nettype wire
